### rtl/core/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants for the gamepad serial port pair.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  // Operation codes carried by each input word
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_STROBE = 2'd1,
    OP_LOAD   = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MULTITAP = 2'd0,
    CFG_EXPANSION = 2'd1,
    CFG_MIC = 2'd2
  } cfg_idx_t;

  localparam int unsigned PORT_CNT_W = 5;
  localparam int unsigned ADPT_CNT_W = 4;

  // Port counters stop here instead of wrapping
  localparam logic [PORT_CNT_W-1:0] PORT_CNT_MAX  = 5'd20;
  // Port bit positions where the second pad and the tail start
  localparam logic [PORT_CNT_W-1:0] PORT_HI_START = 5'd8;
  localparam logic [PORT_CNT_W-1:0] PORT_TAIL     = 5'd16;
  // Multitap signature sits at this count minus the port number
  localparam logic [PORT_CNT_W-1:0] SIG_BASE      = 5'd19;
  // Count after read at which port two shows its Start bit
  localparam logic [PORT_CNT_W-1:0] START_POS     = 5'd4;
  // Adapter counters stop here; bit one then reads one
  localparam logic [ADPT_CNT_W-1:0] ADPT_CNT_MAX  = 4'd8;
  // Start button within a pad byte
  localparam int unsigned START_BIT = 3;

endpackage : gsp_pkg

`default_nettype wire

### rtl/core/gamepad_serial_port_pair_top.sv
// A read word moves from the input register into the result register.
// Throughput: one word per cycle of every kind while reads are not stalled.
// The input register feeds the result register through one level of logic;
// a stalled result holds only a read waiting behind it.
// Reset: rst is synchronous, active high; it clears pads, counters, strobe,
// microphone toggle and the configuration registers.
// ----------------------------------------------------------------------------
// gamepad_serial_port_pair_top
// Two controller serial ports: pad button shift-out, multitap signature,
// expansion adapter stream on bit one and microphone toggle on bit two.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_serial_port_pair_top
  import gsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input word channel
  input  wire logic        item_valid,
  output      logic        item_stall,
  input  wire logic [1:0]  operation,
  input  wire logic        port_select,
  input  wire logic [2:0]  strobe_value,
  input  wire logic [31:0] pad_word,
  input  wire logic [1:0]  open_bus,
  // result word channel
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      logic [7:0]  read_data,
  // configuration write channel
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);

  // configuration
  logic multitap_attached;
  logic expansion_four_player;
  logic mic_replaces_start;

  // block state
  logic [31:0]           pad_buttons;
  logic [PORT_CNT_W-1:0] port_cnt [2];
  logic [ADPT_CNT_W-1:0] adapter_cnt [2];
  logic                  last_strobe;
  logic                  mic_toggle;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic        s1_port;
  logic        s1_strobe;
  logic [31:0] s1_word;
  logic [1:0]  s1_bus;

  // next-state and result logic
  logic                  s1_go;
  logic                  s1_read;
  logic                  out_free;
  logic                  accept;
  logic [PORT_CNT_W-1:0] port_cnt_next;
  logic [ADPT_CNT_W-1:0] adapter_cnt_next;
  logic                  mic_toggle_next;
  logic [7:0]            read_data_next;

  assign cfg_ready = 1'b1;

  // Move the input word on when it needs no output slot or one is free
  assign out_free   = !result_valid || !result_stall;
  assign s1_read    = (s1_op == OP_READ);
  assign s1_go      = s1_valid && (!s1_read || out_free);
  assign item_stall = s1_valid && !s1_go;
  assign accept     = item_valid && !item_stall;

  // Build the read result and the counter updates for the selected port
  always_comb begin
    logic [PORT_CNT_W-1:0] n;
    logic [ADPT_CNT_W-1:0] m;
    logic [7:0]            pad_lo;
    logic [7:0]            pad_hi;
    logic                  sbit;
    logic                  abit;
    logic                  mbit;
    n      = port_cnt[s1_port];
    m      = adapter_cnt[s1_port];
    pad_lo = s1_port ? pad_buttons[15:8]  : pad_buttons[7:0];
    pad_hi = s1_port ? pad_buttons[31:24] : pad_buttons[23:16];

    // serial pad bit
    if (n >= PORT_TAIL) begin
      sbit = 1'b0;
    end else if (n >= PORT_HI_START) begin
      sbit = pad_hi[n[2:0]];
    end else begin
      sbit = pad_lo[n[2:0]];
    end
    if (!multitap_attached) begin
      if (n >= PORT_HI_START) sbit = 1'b1;
    end else if (n == (SIG_BASE - {{(PORT_CNT_W-1){1'b0}}, s1_port})) begin
      sbit = 1'b1;
    end
    port_cnt_next = (n < PORT_CNT_MAX) ? n + 1'b1 : n;

    // mask port two Start in microphone mode
    if (mic_replaces_start && s1_port && (port_cnt_next == START_POS)) begin
      sbit = 1'b0;
    end

    // expansion adapter stream
    abit             = 1'b0;
    adapter_cnt_next = m;
    if (expansion_four_player) begin
      if (m >= ADPT_CNT_MAX) begin
        abit = 1'b1;
      end else begin
        abit             = pad_hi[m[2:0]];
        adapter_cnt_next = m + 1'b1;
      end
    end

    // microphone toggle follows pad two Start
    mbit            = 1'b0;
    mic_toggle_next = mic_toggle;
    if (mic_replaces_start) begin
      if (pad_buttons[8 + START_BIT]) begin
        mic_toggle_next = !mic_toggle;
        mbit            = !mic_toggle;
      end else begin
        mic_toggle_next = 1'b0;
      end
    end

    read_data_next = {s1_bus, 3'b000, mbit, abit, sbit};
  end

  // Hold control, configuration and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid              <= 1'b0;
      result_valid          <= 1'b0;
      multitap_attached     <= 1'b0;
      expansion_four_player <= 1'b0;
      mic_replaces_start    <= 1'b0;
      pad_buttons           <= '0;
      port_cnt[0]           <= '0;
      port_cnt[1]           <= '0;
      adapter_cnt[0]        <= '0;
      adapter_cnt[1]        <= '0;
      last_strobe           <= 1'b0;
      mic_toggle            <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MULTITAP:  multitap_attached     <= cfg_data;
          CFG_EXPANSION: expansion_four_player <= cfg_data;
          CFG_MIC:       mic_replaces_start    <= cfg_data;
          default: ;
        endcase
      end

      // input register occupancy
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      // result register occupancy
      if (s1_go && s1_read) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      // apply the word leaving the input register
      if (s1_go) begin
        case (s1_op)
          OP_READ: begin
            port_cnt[s1_port]    <= port_cnt_next;
            adapter_cnt[s1_port] <= adapter_cnt_next;
            mic_toggle           <= mic_toggle_next;
          end
          OP_STROBE: begin
            if (last_strobe && !s1_strobe) begin
              port_cnt[0]    <= '0;
              port_cnt[1]    <= '0;
              adapter_cnt[0] <= '0;
              adapter_cnt[1] <= '0;
            end
            last_strobe <= s1_strobe;
          end
          OP_LOAD: begin
            pad_buttons <= s1_word;
          end
          default: ;
        endcase
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= operation;
      s1_port   <= port_select;
      s1_strobe <= strobe_value[0];
      s1_word   <= pad_word;
      s1_bus    <= open_bus;
    end
    if (s1_go && s1_read) begin
      read_data <= read_data_next;
    end
  end

endmodule : gamepad_serial_port_pair_top

`default_nettype wire

### rtl/core/gsp_checker.sv
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks for the gamepad serial port pair, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [7:0]  read_data
);

  // Drop any result after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid right after reset");

  // Stall the input only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while result side is free");

  // Keep the unused result bits at zero
  a_zero_bits: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (read_data[5:3] == 3'b000))
    else $error("read_data bits 5:3 not zero");

  // Hold a stalled result word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(read_data)))
    else $error("stalled result word changed");

endmodule : gsp_checker

bind gamepad_serial_port_pair_top gsp_checker u_gsp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .read_data    (read_data)
);

`default_nettype wire

### sim/tb_gamepad_serial_port_pair_top.sv
// ----------------------------------------------------------------------------
// tb_gamepad_serial_port_pair_top
// Self-checking bench for the controller port pair. A directed probe table
// covers reset reads, saturated pads, strobe clearing, the unused opcode and
// the multitap, adapter and microphone modes. Random frames then follow
// (load, strobe high, strobe low, a burst of reads), mixed with noise, across
// every mode setting. An in-bench model predicts each read word that no typed
// probe row gives, and a scoreboard compares it with the DUT output while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gamepad_serial_port_pair_top;
  import gsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_WORDS = 112;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned SETTLE_CYCLES = 4;

  // one row of the directed probe list; want is used only when typed is set
  typedef struct packed {
    logic        cfg_load;
    logic [2:0]  cfg_bits;   // {mic, expansion, multitap}
    logic [1:0]  op;
    logic        port;
    logic [2:0]  sv;
    logic [31:0] word;
    logic [1:0]  ob;
    logic        typed;
    logic [7:0]  want;
  } probe_row_t;

  localparam probe_row_t PROBE_ROWS [19] = '{
    '{1'b0, 3'b000, OP_READ,   1'b0, 3'd0, 32'h0000_0000, 2'd0, 1'b1, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b1, 3'd0, 32'h0000_0000, 2'd3, 1'b1, 8'hC0},
    '{1'b0, 3'b000, OP_LOAD,   1'b0, 3'd0, 32'hFFFF_FFFF, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_STROBE, 1'b0, 3'd7, 32'h0000_0000, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_STROBE, 1'b1, 3'd6, 32'h0000_0000, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b0, 3'd0, 32'h0000_0000, 2'd1, 1'b1, 8'h41},
    '{1'b0, 3'b000, OP_READ,   1'b1, 3'd0, 32'h0000_0000, 2'd2, 1'b1, 8'h81},
    '{1'b0, 3'b000, OP_UNUSED, 1'b1, 3'd7, 32'hFFFF_FFFF, 2'd3, 1'b0, 8'h00},
    '{1'b1, 3'b111, OP_LOAD,   1'b0, 3'd0, 32'h9C6E_08A5, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_STROBE, 1'b0, 3'd1, 32'h0000_0000, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_STROBE, 1'b0, 3'd0, 32'h0000_0000, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b1, 3'd0, 32'h0000_0000, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b1, 3'd0, 32'h0000_0000, 2'd1, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b1, 3'd0, 32'h0000_0000, 2'd2, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b1, 3'd0, 32'h0000_0000, 2'd3, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b1, 3'd0, 32'h0000_0000, 2'd0, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b0, 3'd0, 32'h0000_0000, 2'd3, 1'b0, 8'h00},
    '{1'b0, 3'b000, OP_READ,   1'b0, 3'd0, 32'h0000_0000, 2'd0, 1'b0, 8'h00},
    '{1'b1, 3'b000, OP_STROBE, 1'b1, 3'd5, 32'h0000_0000, 2'd2, 1'b0, 8'h00}
  };

  // mode settings per random phase, {mic, expansion, multitap}
  localparam logic [2:0] MODE_PLAN [PHASES] = '{
    3'b000, 3'b111, 3'b001, 3'b010, 3'b100, 3'b101, 3'b011, 3'b110
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  operation = OP_READ;
  logic        port_select = 1'b0;
  logic [2:0]  strobe_value = 3'd0;
  logic [31:0] pad_word = 32'd0;
  logic [1:0]  open_bus = 2'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  read_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_MULTITAP;
  logic        cfg_data = 1'b0;

  gamepad_serial_port_pair_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .port_select  (port_select),
    .strobe_value (strobe_value),
    .pad_word     (pad_word),
    .open_bus     (open_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .read_data    (read_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state, mirrored from the accepted words and mode writes
  logic [7:0]            pad_bytes [4];
  logic [PORT_CNT_W-1:0] port_cnt  [2];
  logic [ADPT_CNT_W-1:0] adpt_cnt  [2];
  logic                  strobe_q;
  logic                  mic_q;
  logic                  mode_multitap;
  logic                  mode_expansion;
  logic                  mode_mic;

  logic [7:0] read_data_due [$];
  int unsigned mismatches = 0;
  bit          quiet = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;

  // Advance the port model by one word; returns 1 with the read word for reads
  function automatic logic pad_port_response(input logic [1:0] op, input logic port,
                                             input logic [2:0] sv, input logic [31:0] word,
                                             input logic [1:0] ob, output logic [7:0] rd);
    logic [PORT_CNT_W-1:0] n;
    logic [ADPT_CNT_W-1:0] a;
    logic b0, b1, b2;
    rd = 8'h00;
    if (op == OP_READ) begin
      n = port_cnt[port];
      if (n >= PORT_TAIL) b0 = 1'b0;
      else if (n >= PORT_HI_START) b0 = pad_bytes[2 + port][n[2:0]];
      else b0 = pad_bytes[port][n[2:0]];
      // multitap signature, or all ones once the pad is done
      if (!mode_multitap) begin
        if (n >= PORT_HI_START) b0 = 1'b1;
      end else if (n == SIG_BASE - {4'd0, port}) begin
        b0 = 1'b1;
      end
      if (n < PORT_CNT_MAX) port_cnt[port] = n + 1'b1;
      // microphone mode hides port two Start
      if (mode_mic && port && port_cnt[1] == START_POS) b0 = 1'b0;
      b1 = 1'b0;
      if (mode_expansion) begin
        a = adpt_cnt[port];
        if (a >= ADPT_CNT_MAX) begin
          b1 = 1'b1;
        end else begin
          b1 = pad_bytes[2 + port][a[2:0]];
          adpt_cnt[port] = a + 1'b1;
        end
      end
      b2 = 1'b0;
      if (mode_mic) begin
        if (pad_bytes[1][START_BIT]) begin
          mic_q = ~mic_q;
          b2 = mic_q;
        end else begin
          mic_q = 1'b0;
        end
      end
      rd = {ob, 3'b000, b2, b1, b0};
      return 1'b1;
    end
    if (op == OP_STROBE) begin
      // falling strobe clears every counter
      if (strobe_q && !sv[0]) begin
        port_cnt[0] = '0;
        port_cnt[1] = '0;
        adpt_cnt[0] = '0;
        adpt_cnt[1] = '0;
      end
      strobe_q = sv[0];
    end else if (op == OP_LOAD) begin
      pad_bytes[0] = word[7:0];
      pad_bytes[1] = word[15:8];
      pad_bytes[2] = word[23:16];
      pad_bytes[3] = word[31:24];
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Offer one input word, hold it until accepted, then predict its read word
  task automatic offer_word(input logic [1:0] op, input logic port, input logic [2:0] sv,
                            input logic [31:0] word, input logic [1:0] ob,
                            input logic typed, input logic [7:0] want);
    logic [7:0] rd;
    logic       has_rd;
    if (!quiet && $urandom_range(0, 99) < 17) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    operation    <= op;
    port_select  <= port;
    strobe_value <= sv;
    pad_word     <= word;
    open_bus     <= ob;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    has_rd = pad_port_response(op, port, sv, word, ob, rd);
    if (has_rd) read_data_due.push_back(typed ? want : rd);
  endtask

  task automatic offer_rand(input logic [1:0] op);
    offer_word(op, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
               2'($urandom_range(0, 3)), 1'b0, 8'h00);
  endtask

  // Drop valid and wait until the DUT has emptied
  task automatic settle();
    item_valid <= 1'b0;
    while (read_data_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input cfg_idx_t idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MULTITAP:  mode_multitap  = val;
      CFG_EXPANSION: mode_expansion = val;
      CFG_MIC:       mode_mic       = val;
      default: ;
    endcase
  endtask

  task automatic apply_modes(input logic [2:0] bits);
    settle();
    write_mode(CFG_MULTITAP, bits[0]);
    write_mode(CFG_EXPANSION, bits[1]);
    write_mode(CFG_MIC, bits[2]);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= !quiet && ($urandom_range(0, 99) < 17);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && result_valid && !result_stall) begin
      if (read_data_due.size() == 0) begin
        flag_mismatch("unexpected read_data", 8'h00, read_data);
      end else begin
        want = read_data_due.pop_front();
        if (read_data !== want) flag_mismatch("read_data", want, read_data);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("gamepad_serial_port_pair_top: mismatch");
    $finish;
  end

  initial begin
    int unsigned sent;
    logic [1:0]  hi2;
    logic [1:0]  op;
    int unsigned burst;
    for (int i = 0; i < 4; i++) pad_bytes[i] = 8'h00;
    for (int i = 0; i < 2; i++) begin
      port_cnt[i] = '0;
      adpt_cnt[i] = '0;
    end
    strobe_q       = 1'b0;
    mic_q          = 1'b0;
    mode_multitap  = 1'b0;
    mode_expansion = 1'b0;
    mode_mic       = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed probes
    foreach (PROBE_ROWS[i]) begin
      if (PROBE_ROWS[i].cfg_load) apply_modes(PROBE_ROWS[i].cfg_bits);
      offer_word(PROBE_ROWS[i].op, PROBE_ROWS[i].port, PROBE_ROWS[i].sv,
                 PROBE_ROWS[i].word, PROBE_ROWS[i].ob, PROBE_ROWS[i].typed,
                 PROBE_ROWS[i].want);
    end

    // random frames per mode setting
    for (int ph = 0; ph < PHASES; ph++) begin
      apply_modes(MODE_PLAN[ph]);
      quiet = (ph == 1);
      sent = 0;
      if (ph == 3) begin
        // back up the result side while reads keep coming
        hold_asked++;
        repeat (30) offer_rand(OP_READ);
        sent = 30;
      end
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 80) begin
          offer_rand(OP_LOAD);
          hi2 = 2'($urandom_range(0, 3));
          offer_word(OP_STROBE, 1'($urandom_range(0, 1)), {hi2, 1'b1}, $urandom,
                     2'($urandom_range(0, 3)), 1'b0, 8'h00);
          hi2 = 2'($urandom_range(0, 3));
          offer_word(OP_STROBE, 1'($urandom_range(0, 1)), {hi2, 1'b0}, $urandom,
                     2'($urandom_range(0, 3)), 1'b0, 8'h00);
          burst = $urandom_range(1, 44);
          repeat (burst) offer_rand(OP_READ);
          sent += 3 + burst;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            op = 2'($urandom_range(0, 3));
            offer_rand(op);
            if (op != OP_UNUSED) sent++;
          end
        end
      end
    end

    quiet = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (read_data_due.size() != 0) flag_mismatch("missing read_data", read_data_due[0], 8'h00);
    if (mismatches == 0)
      $display("gamepad_serial_port_pair_top: match");
    else
      $display("gamepad_serial_port_pair_top: mismatch");
    $finish;
  end

endmodule : tb_gamepad_serial_port_pair_top

`default_nettype wire
